### sv/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants
// Frame layout, status codes and the frame verdict handed from unpacker to
// result sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    localparam int NUM_CHANS  = 16;
    localparam int CHAN_BITS  = 11;
    localparam int ACC_BITS   = 18;
    localparam int POS_BITS   = 5;
    localparam int IDX_BITS   = 4;

    localparam logic [7:0] START_BYTE = 8'h0F;
    localparam logic [7:0] END_BYTE   = 8'h00;

    localparam logic [POS_BITS-1:0] LAST_DATA_POS = 5'd22;
    localparam logic [POS_BITS-1:0] FLAG_POS      = 5'd23;
    localparam logic [POS_BITS-1:0] END_POS       = 5'd24;
    localparam logic [POS_BITS-1:0] IDLE_POS      = 5'd25;

    localparam int LOST_BIT     = 2;
    localparam int FAILSAFE_BIT = 3;

    localparam logic [1:0] LINK_OK       = 2'd0;
    localparam logic [1:0] LINK_LOST     = 2'd1;
    localparam logic [1:0] LINK_FAILSAFE = 2'd2;

    typedef logic [NUM_CHANS-1:0][CHAN_BITS-1:0] chan_arr_t;

    typedef struct packed {
        logic       load;
        logic       good;
        logic       digital_one;
        logic       digital_two;
        logic [1:0] link_status;
        logic       end_pending;
    } verdict_t;

endpackage

`default_nettype wire

### sv/sfd_unpack.sv
// ----------------------------------------------------------------------------
// sfd_unpack: frame byte tracker and channel unpacker
// Follows the byte position, unpacks data bytes LSB first into 11-bit
// channels and judges the frame on its end byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_unpack (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              frame_start,
    output sfd_pkg::chan_arr_t     channels,
    output sfd_pkg::verdict_t      verdict
);
    import sfd_pkg::*;

    logic [POS_BITS-1:0]  pos_reg,    pos_next;
    logic                 sgood_reg,  sgood_next;
    logic [ACC_BITS-1:0]  acc_reg,    acc_next;
    logic [4:0]           held_reg,   held_next;
    logic [4:0]           count_reg,  count_next;
    logic [7:0]           flag_reg,   flag_next;
    logic [CHAN_BITS-1:0] store_reg [NUM_CHANS];

    logic [ACC_BITS-1:0]  acc_or;
    logic [4:0]           held_sum;
    logic                 chan_done;
    logic                 data_pos;
    logic                 store_we;

    assign acc_or    = acc_reg | (ACC_BITS'(rx_byte) << held_reg);
    assign held_sum  = held_reg + 5'd8;
    assign chan_done = (held_sum >= 5'(CHAN_BITS));
    assign data_pos  = (pos_reg != '0) && (pos_reg <= LAST_DATA_POS);
    assign store_we  = accept && !frame_start && data_pos && chan_done && !count_reg[4];

    always_comb
    begin
        pos_next   = pos_reg;
        sgood_next = sgood_reg;
        acc_next   = acc_reg;
        held_next  = held_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        if (accept)
        begin
            if (frame_start)
            begin
                sgood_next = (rx_byte == START_BYTE);
                acc_next   = '0;
                held_next  = '0;
                count_next = '0;
                flag_next  = '0;
                pos_next   = 5'd1;
            end
            else if (data_pos)
            begin
                pos_next = pos_reg + 5'd1;
                if (chan_done)
                begin
                    acc_next   = acc_or >> CHAN_BITS;
                    held_next  = held_sum - 5'(CHAN_BITS);
                    count_next = count_reg + 5'd1;
                end
                else
                begin
                    acc_next  = acc_or;
                    held_next = held_sum;
                end
            end
            else if (pos_reg == FLAG_POS)
            begin
                flag_next = rx_byte;
                pos_next  = END_POS;
            end
            else if (pos_reg == END_POS)
            begin
                pos_next = IDLE_POS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= IDLE_POS;
            sgood_reg <= 1'b0;
            acc_reg   <= '0;
            held_reg  <= '0;
            count_reg <= '0;
            flag_reg  <= '0;
        end
        else
        begin
            pos_reg   <= pos_next;
            sgood_reg <= sgood_next;
            acc_reg   <= acc_next;
            held_reg  <= held_next;
            count_reg <= count_next;
            flag_reg  <= flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[IDX_BITS-1:0]] <= acc_or[CHAN_BITS-1:0];
        end
    end

    always_comb
    begin
        for (int i = 0; i < NUM_CHANS; i++)
        begin
            channels[i] = store_reg[i];
        end
    end

    always_comb
    begin
        verdict.load        = accept && !frame_start && (pos_reg == END_POS);
        verdict.good        = sgood_reg && (rx_byte == END_BYTE);
        verdict.digital_one = flag_reg[0];
        verdict.digital_two = flag_reg[1];
        if (flag_reg[FAILSAFE_BIT])
            verdict.link_status = LINK_FAILSAFE;
        else if (flag_reg[LOST_BIT])
            verdict.link_status = LINK_LOST;
        else
            verdict.link_status = LINK_OK;
        verdict.end_pending = (pos_reg == END_POS);
    end

endmodule

`default_nettype wire

### sv/sfd_emit.sv
// ----------------------------------------------------------------------------
// sfd_emit: result sequencer
// Snapshots the channels of a judged frame and plays them out one request
// per cycle while out_ready is high, or a single error request for a bad frame.
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_emit (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire sfd_pkg::verdict_t           verdict,
    input  wire sfd_pkg::chan_arr_t          channels,
    output logic                             busy,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [sfd_pkg::IDX_BITS-1:0]     channel_index,
    output logic [sfd_pkg::CHAN_BITS-1:0]    channel_value,
    output logic                             digital_one,
    output logic                             digital_two,
    output logic [1:0]                       link_status,
    output logic                             frame_ok,
    output logic                             last_of_run
);
    import sfd_pkg::*;

    logic                busy_reg, busy_next;
    logic [IDX_BITS-1:0] idx_reg,  idx_next;
    logic                err_reg,  err_next;
    chan_arr_t           snap_reg;
    logic                d1_reg, d2_reg;
    logic [1:0]          link_reg;
    logic                fire;
    logic                last;

    assign fire = busy_reg && out_ready;
    assign last = err_reg || (idx_reg == IDX_BITS'(NUM_CHANS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        err_next  = err_reg;
        if (verdict.load)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
            err_next  = !verdict.good;
        end
        else if (fire)
        begin
            if (last)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (verdict.load)
        begin
            snap_reg <= channels;
            d1_reg   <= verdict.digital_one;
            d2_reg   <= verdict.digital_two;
            link_reg <= verdict.link_status;
        end
    end

    assign busy          = busy_reg;
    assign out_valid     = busy_reg;
    assign channel_index = err_reg ? '0 : idx_reg;
    assign channel_value = err_reg ? '0 : snap_reg[idx_reg];
    assign digital_one   = err_reg ? 1'b0 : d1_reg;
    assign digital_two   = err_reg ? 1'b0 : d2_reg;
    assign link_status   = err_reg ? LINK_OK : link_reg;
    assign frame_ok      = !err_reg;
    assign last_of_run   = last;

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        verdict.load |-> !busy_reg)
        else $error("frame verdict while a run is still pending");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last && !verdict.load) |=> !out_valid)
        else $error("run continues after its last request");

    a_err_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !frame_ok) |-> (last_of_run && channel_value == '0))
        else $error("error request malformed");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !last && !verdict.load) |=> (idx_reg == $past(idx_reg) + 1'b1))
        else $error("channel index skipped");

endmodule

`default_nettype wire

### sv/sbus_frame_decoder.sv
// ----------------------------------------------------------------------------
// sbus_frame_decoder: 16-channel 11-bit serial frame decoder
// Unpacks 25-byte frames into channel requests with digital and link status.
// ----------------------------------------------------------------------------
// Input stream: one received byte per request on s_axis_tdata, with
// s_axis_tuser high on the first byte of a frame. Such a byte always begins
// a new frame, dropping any partial one. Bytes outside a frame are dropped.
// Output stream: on the end byte of a good frame, 16 channel requests follow,
// one per cycle while the receiver is ready, starting the cycle after the end
// byte is taken; tlast marks channel 15. A bad start or end byte gives one error
// request (tuser low, tlast high) instead.
// Throughput: one input byte per cycle. The 16-request run plays out from a
// snapshot, so the next frame's bytes flow in meanwhile; only the end byte
// of a frame waits (tready low) while the previous run is still pending.
// A receiver stall holds the current request and the run.
// Reset clears the byte tracker to idle (waiting for a frame start) and drops
// any pending run; the channel store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module sbus_frame_decoder (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    input  wire logic        s_axis_tuser,   // [0] frame_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,   // [3:0] channel_index, [14:4] channel_value,
                                             // [15] digital_one, [16] digital_two,
                                             // [18:17] link_status, [23:19] zero
    output logic             m_axis_tuser,   // [0] frame_ok
    output logic             m_axis_tlast    // last_of_run
);
    import sfd_pkg::*;

    chan_arr_t            channels;
    verdict_t             verdict;
    logic                 busy;
    logic                 accept;
    logic [IDX_BITS-1:0]  channel_index;
    logic [CHAN_BITS-1:0] channel_value;
    logic                 digital_one;
    logic                 digital_two;
    logic [1:0]           link_status;

    assign s_axis_tready = !(verdict.end_pending && busy);
    assign accept        = s_axis_tvalid && s_axis_tready;

    sfd_unpack u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .rx_byte     (s_axis_tdata),
        .frame_start (s_axis_tuser),
        .channels    (channels),
        .verdict     (verdict)
    );

    sfd_emit u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .verdict       (verdict),
        .channels      (channels),
        .busy          (busy),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .channel_index (channel_index),
        .channel_value (channel_value),
        .digital_one   (digital_one),
        .digital_two   (digital_two),
        .link_status   (link_status),
        .frame_ok      (m_axis_tuser),
        .last_of_run   (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, link_status, digital_two, digital_one,
                           channel_value, channel_index};

endmodule

`default_nettype wire

### dv/sbus_frame_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sbus_frame_decoder_tb: self-checking bench for the serial frame decoder
// Streams 25-byte frames (good, bad start, bad end, cut short, stray bytes)
// into the decoder; in the directed tests both stream sides stall at random.
// A built-in decoder of its own predicts every channel request, and each request
// taken from the output is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module sbus_frame_decoder_tb;

    import sfd_pkg::*;

    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_RANDOM = 2;
    localparam int FILL_SPLIT  = 3;

    typedef struct packed {
        logic [3:0]  chan_idx;
        logic [10:0] chan_val;
        logic        dig_one;
        logic        dig_two;
        logic [1:0]  link;
        logic        ok;
        logic        last;
    } channel_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    bit idle_on = 1'b1;
    int errors = 0;

    channel_result_t expected_channels[$];
    channel_result_t want;

    logic [4:0]  byte_pos = IDLE_POS;
    logic        start_ok = 1'b0;
    logic [17:0] bit_acc = '0;
    logic [4:0]  bits_in_acc = '0;
    logic [4:0]  chan_cnt = '0;
    logic [10:0] chan_store [0:NUM_CHANS-1];
    logic [7:0]  flag_reg = '0;

    logic [7:0]  payload [0:21];

    sbus_frame_decoder i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic void unpack_data_byte(input logic [7:0] b);
        logic [31:0] acc_wide;
        acc_wide = 32'(bit_acc) | (32'(b) << bits_in_acc);
        bits_in_acc = bits_in_acc + 5'd8;
        while (bits_in_acc >= CHAN_BITS)
        begin
            if (chan_cnt < NUM_CHANS)
                chan_store[chan_cnt[3:0]] = acc_wide[10:0];
            chan_cnt = chan_cnt + 5'd1;
            acc_wide = acc_wide >> CHAN_BITS;
            bits_in_acc = bits_in_acc - 5'(CHAN_BITS);
        end
        bit_acc = acc_wide[17:0];
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic frame_start);
        channel_result_t r;
        logic [1:0] link;
        if (frame_start)
        begin
            start_ok = (b == START_BYTE);
            bit_acc = '0;
            bits_in_acc = '0;
            chan_cnt = '0;
            flag_reg = '0;
            byte_pos = 5'd1;
            return;
        end
        if (byte_pos == 5'd0 || byte_pos >= IDLE_POS)
            return;
        if (byte_pos <= LAST_DATA_POS)
        begin
            unpack_data_byte(b);
            byte_pos = byte_pos + 5'd1;
        end
        else if (byte_pos == FLAG_POS)
        begin
            flag_reg = b;
            byte_pos = byte_pos + 5'd1;
        end
        else
        begin
            byte_pos = IDLE_POS;
            if (start_ok && b == END_BYTE)
            begin
                if (flag_reg[FAILSAFE_BIT])
                    link = LINK_FAILSAFE;
                else if (flag_reg[LOST_BIT])
                    link = LINK_LOST;
                else
                    link = LINK_OK;
                for (int k = 0; k < NUM_CHANS; k++)
                begin
                    r.chan_idx = 4'(k);
                    r.chan_val = chan_store[k];
                    r.dig_one  = flag_reg[0];
                    r.dig_two  = flag_reg[1];
                    r.link     = link;
                    r.ok       = 1'b1;
                    r.last     = (k == NUM_CHANS - 1);
                    expected_channels.push_back(r);
                end
            end
            else
            begin
                r = '0;
                r.link = LINK_OK;
                r.last = 1'b1;
                expected_channels.push_back(r);
            end
        end
    endfunction

    function automatic void check_field(input string what, input logic [31:0] want_v,
                                        input logic [31:0] got_v);
        if (want_v !== got_v)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want_v, got_v);
            errors++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_channels.size() == 0)
                begin
                    $display("%0t: unexpected request, expected none, actual tdata %h", $time,
                             m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = expected_channels.pop_front();
                    check_field("channel_index", 32'(want.chan_idx), 32'(m_axis_tdata[3:0]));
                    check_field("channel_value", 32'(want.chan_val), 32'(m_axis_tdata[14:4]));
                    check_field("digital_one", 32'(want.dig_one), 32'(m_axis_tdata[15]));
                    check_field("digital_two", 32'(want.dig_two), 32'(m_axis_tdata[16]));
                    check_field("link_status", 32'(want.link), 32'(m_axis_tdata[18:17]));
                    check_field("tdata padding", 32'd0, 32'(m_axis_tdata[23:19]));
                    check_field("frame_ok", 32'(want.ok), 32'(m_axis_tuser));
                    check_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                decode_byte(s_axis_tdata, s_axis_tuser);
        end
    end

    always @(posedge clk)
        m_axis_tready <= idle_on ? ($urandom_range(0, 99) >= 26) : 1'b1;

    task automatic send_byte(input logic [7:0] b, input logic frame_start);
        while (idle_on && $urandom_range(0, 99) < 26)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= frame_start;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic send_frame(input logic [7:0] start_b, input logic [7:0] flags_b,
                              input logic [7:0] end_b, input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i == 0)
                send_byte(start_b, 1'b1);
            else if (i <= 22)
                send_byte(payload[i-1], 1'b0);
            else if (i == 23)
                send_byte(flags_b, 1'b0);
            else
                send_byte(end_b, 1'b0);
        end
    endtask

    task automatic fill_payload(input int mode);
        for (int i = 0; i < 22; i++)
            payload[i] = (mode == FILL_ZERO) ? 8'h00 :
                         (mode == FILL_ONES) ? 8'hFF :
                         (mode == FILL_SPLIT) ? ((i < 11) ? 8'h00 : 8'hFF) :
                         8'($urandom);
    endtask

    task automatic drain;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_channels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_stray_bytes;
        send_byte(START_BYTE, 1'b0);
        send_byte(END_BYTE, 1'b0);
        send_byte(8'hFF, 1'b0);
        drain();
    endtask

    task automatic test_channel_range;
        fill_payload(FILL_SPLIT);
        send_frame(START_BYTE, 8'h0C, END_BYTE, 25);
        drain();
    endtask

    task automatic test_link_status;
        fill_payload(FILL_RANDOM);
        send_frame(START_BYTE, 8'h07, END_BYTE, 25);
        drain();
    endtask

    task automatic test_bad_frames;
        fill_payload(FILL_RANDOM);
        send_frame(8'hF0, 8'h00, END_BYTE, 25);
        send_frame(START_BYTE, 8'h08, 8'h80, 25);
        drain();
    endtask

    task automatic test_frame_restart;
        fill_payload(FILL_ONES);
        send_frame(START_BYTE, 8'h00, END_BYTE, 24);
        fill_payload(FILL_RANDOM);
        send_frame(START_BYTE, 8'hF3, END_BYTE, 25);
        drain();
    endtask

    task automatic test_random_traffic(input bit stalls, input int byte_budget);
        int sent;
        int kind;
        int n;
        logic [7:0] start_b;
        logic [7:0] end_b;
        idle_on = stalls;
        sent = 0;
        while (sent < byte_budget)
        begin
            kind = $urandom_range(0, 9);
            start_b = START_BYTE;
            end_b = END_BYTE;
            n = 25;
            fill_payload(FILL_RANDOM);
            if (kind == 6)
            begin
                start_b = 8'($urandom);
                if (start_b == START_BYTE)
                    start_b = ~start_b;
            end
            else if (kind == 7)
                end_b = 8'($urandom_range(1, 255));
            else if (kind == 8)
                n = $urandom_range(1, 24);
            if (kind == 9)
            begin
                repeat ($urandom_range(1, 4))
                    send_byte(8'($urandom), 1'b0);
            end
            else
            begin
                send_frame(start_b, 8'($urandom), end_b, n);
                sent += n;
            end
        end
        drain();
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_stray_bytes();
        test_channel_range();
        test_link_status();
        test_bad_frames();
        test_frame_restart();
        test_random_traffic(1'b0, 25);
        repeat (40) @(posedge clk);
        if (errors == 0 && expected_channels.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
